// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define NKVP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that expr never holds outside reset.
`define NKVP_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/nkvp_pkg.sv =====
`timescale 1ns / 1ps

package nkvp_pkg;

    typedef struct packed {
        logic               command;
        logic [3:0]         token_kind;
        logic signed [63:0] token_value;
        logic [3:0]         next_kind;
    } t_in;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [2:0]         kind;
        logic [2:0]         relation;
        logic               name_is_number;
        logic signed [63:0] payload;
        logic [3:0]         error_code;
        logic [6:0]         depth;
        logic               last;
    } t_out;

    typedef enum logic [3:0] {
        S_ROOT  = 4'd0,
        S_NAME  = 4'd1,
        S_EQ    = 4'd2,
        S_GT    = 4'd3,
        S_GE    = 4'd4,
        S_LT    = 4'd5,
        S_LE    = 4'd6,
        S_OPEN  = 4'd7,
        S_INTL  = 4'd8,
        S_DBLL  = 4'd9,
        S_CMPL  = 4'd10,
        S_STRL  = 4'd11,
        S_BOOLL = 4'd12
    } t_pstate;

    typedef enum logic [1:0] {
        D_KEEP,
        D_INC,
        D_DEC,
        D_ZERO
    } t_dop;

    typedef struct packed {
        t_pstate    state;
        t_dop       dop;
        logic       fail;
        logic [3:0] err;
        logic       mk_we;
        logic       mk_val;
        logic       push_we;
        logic       restart;
        logic [1:0] cnt;
    } t_ctl;

    localparam logic [3:0] K_STR  = 4'd0;
    localparam logic [3:0] K_INT  = 4'd1;
    localparam logic [3:0] K_DBL  = 4'd2;
    localparam logic [3:0] K_BOOL = 4'd3;
    localparam logic [3:0] K_EQ   = 4'd4;
    localparam logic [3:0] K_OB   = 4'd5;
    localparam logic [3:0] K_CB   = 4'd6;
    localparam logic [3:0] K_LT   = 4'd7;
    localparam logic [3:0] K_GT   = 4'd8;

    localparam logic [2:0] EV_ENTRY  = 3'd0;
    localparam logic [2:0] EV_SCALAR = 3'd1;
    localparam logic [2:0] EV_CONT   = 3'd2;
    localparam logic [2:0] EV_MEMBER = 3'd3;
    localparam logic [2:0] EV_CMEM   = 3'd4;
    localparam logic [2:0] EV_CLOSE  = 3'd5;
    localparam logic [2:0] EV_ERROR  = 3'd6;
    localparam logic [2:0] EV_END    = 3'd7;

    localparam logic [2:0] CK_CMP   = 3'd0;
    localparam logic [2:0] CK_INTL  = 3'd1;
    localparam logic [2:0] CK_DBLL  = 3'd2;
    localparam logic [2:0] CK_CMPL  = 3'd3;
    localparam logic [2:0] CK_STRL  = 3'd4;
    localparam logic [2:0] CK_BOOLL = 3'd5;
    localparam logic [2:0] CK_EMPTY = 3'd6;

    localparam logic [2:0] SK_INT  = 3'd0;
    localparam logic [2:0] SK_DBL  = 3'd1;
    localparam logic [2:0] SK_BOOL = 3'd2;
    localparam logic [2:0] SK_STR  = 3'd3;

    localparam logic [2:0] REL_EQ = 3'd0;
    localparam logic [2:0] REL_GT = 3'd1;
    localparam logic [2:0] REL_GE = 3'd2;
    localparam logic [2:0] REL_LT = 3'd3;
    localparam logic [2:0] REL_LE = 3'd4;

    localparam logic [3:0] ERR_CLOSE    = 4'd0;
    localparam logic [3:0] ERR_CMP      = 4'd1;
    localparam logic [3:0] ERR_NAME     = 4'd2;
    localparam logic [3:0] ERR_EQ       = 4'd3;
    localparam logic [3:0] ERR_REL      = 4'd4;
    localparam logic [3:0] ERR_OPENCOMB = 4'd5;
    localparam logic [3:0] ERR_OPEN     = 4'd6;
    localparam logic [3:0] ERR_INTL     = 4'd7;
    localparam logic [3:0] ERR_DBLL     = 4'd8;
    localparam logic [3:0] ERR_CMPL     = 4'd9;
    localparam logic [3:0] ERR_STRL     = 4'd10;
    localparam logic [3:0] ERR_BOOLL    = 4'd11;
    localparam logic [3:0] ERR_END      = 4'd12;
    localparam logic [3:0] ERR_DEEP     = 4'd13;

endpackage

// ===== rtl/core/nkvp_step.sv =====
`timescale 1ns / 1ps

module nkvp_step #(
    parameter int MAX_DEPTH = 64,
    localparam int DW = $clog2(MAX_DEPTH + 1)
) (
    input  nkvp_pkg::t_in     i_tok,
    input  nkvp_pkg::t_pstate i_state,
    input  logic              i_failed,
    input  logic [3:0]        i_err,
    input  logic [DW-1:0]     i_depth,
    input  logic              i_mark,
    output nkvp_pkg::t_ctl    o_ctl,
    output nkvp_pkg::t_out    o_res0,
    output nkvp_pkg::t_out    o_res1
);

    typedef enum logic [2:0] {
        A_NONE,
        A_PUSH,
        A_SCALAR,
        A_CLOSE,
        A_RCLOSE,
        A_MEMBER,
        A_FAIL
    } t_act;

    function automatic nkvp_pkg::t_out mk(
        input logic [2:0]         ev,
        input logic [2:0]         kind,
        input logic [2:0]         rel,
        input logic               num,
        input logic signed [63:0] pay,
        input logic [3:0]         code,
        input logic [DW-1:0]      d
    );
        nkvp_pkg::t_out r;
        r.event_res      = ev;
        r.kind           = kind;
        r.relation       = rel;
        r.name_is_number = num;
        r.payload        = pay;
        r.error_code     = code;
        r.depth          = 7'(d);
        r.last           = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic [3:0]         tk;
        logic [3:0]         nk;
        logic signed [63:0] pay;
        t_act               act;
        logic               set_v;
        logic [2:0]         set_ck;
        logic [2:0]         ev;
        logic [2:0]         kind;
        logic [2:0]         rel;
        logic               num;
        logic [3:0]         code;
        logic               has_eq;
        nkvp_pkg::t_pstate  eq_st;
        nkvp_pkg::t_out     main;
        logic               has_main;

        tk     = i_tok.token_kind;
        nk     = i_tok.next_kind;
        pay    = i_tok.token_value;
        act    = A_NONE;
        set_v  = 1'b0;
        set_ck = nkvp_pkg::CK_CMP;
        ev     = nkvp_pkg::EV_ENTRY;
        kind   = 3'd0;
        rel    = nkvp_pkg::REL_EQ;
        num    = 1'b0;
        code   = nkvp_pkg::ERR_CMP;
        has_eq = 1'b0;
        eq_st  = nkvp_pkg::S_ROOT;
        main   = mk(nkvp_pkg::EV_ERROR, 3'd0, 3'd0, 1'b0, 64'sd0, 4'd0, i_depth);

        o_ctl         = '0;
        o_ctl.state   = i_state;
        o_ctl.dop     = nkvp_pkg::D_KEEP;
        o_res0        = main;
        o_res1        = main;

        unique case (i_state)
            nkvp_pkg::S_ROOT: begin
                if (tk == nkvp_pkg::K_STR || tk == nkvp_pkg::K_INT) begin
                    o_ctl.state = nkvp_pkg::S_NAME;
                    act = A_PUSH;
                    ev  = nkvp_pkg::EV_ENTRY;
                    num = (tk == nkvp_pkg::K_INT);
                end else if (tk == nkvp_pkg::K_CB) begin
                    act = A_RCLOSE;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_CMP;
                end
            end
            nkvp_pkg::S_NAME: begin
                if (tk == nkvp_pkg::K_EQ) begin
                    o_ctl.state = nkvp_pkg::S_EQ;
                end else if (tk == nkvp_pkg::K_GT) begin
                    o_ctl.state = nkvp_pkg::S_GT;
                end else if (tk == nkvp_pkg::K_LT) begin
                    o_ctl.state = nkvp_pkg::S_LT;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_NAME;
                end
            end
            nkvp_pkg::S_EQ: begin
                rel = nkvp_pkg::REL_EQ;
                if (tk == nkvp_pkg::K_OB) begin
                    o_ctl.state = nkvp_pkg::S_OPEN;
                end else if (tk == nkvp_pkg::K_INT) begin
                    act  = A_SCALAR;
                    kind = nkvp_pkg::SK_INT;
                end else if (tk == nkvp_pkg::K_DBL) begin
                    act  = A_SCALAR;
                    kind = nkvp_pkg::SK_DBL;
                end else if (tk == nkvp_pkg::K_BOOL) begin
                    act  = A_SCALAR;
                    kind = nkvp_pkg::SK_BOOL;
                end else if (tk == nkvp_pkg::K_STR) begin
                    act  = A_SCALAR;
                    kind = nkvp_pkg::SK_STR;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_EQ;
                end
            end
            nkvp_pkg::S_GT, nkvp_pkg::S_GE, nkvp_pkg::S_LT, nkvp_pkg::S_LE: begin
                unique case (i_state)
                    nkvp_pkg::S_GT: begin
                        rel    = nkvp_pkg::REL_GT;
                        has_eq = 1'b1;
                        eq_st  = nkvp_pkg::S_GE;
                    end
                    nkvp_pkg::S_GE: rel = nkvp_pkg::REL_GE;
                    nkvp_pkg::S_LT: begin
                        rel    = nkvp_pkg::REL_LT;
                        has_eq = 1'b1;
                        eq_st  = nkvp_pkg::S_LE;
                    end
                    default: rel = nkvp_pkg::REL_LE;
                endcase
                if (has_eq && tk == nkvp_pkg::K_EQ) begin
                    o_ctl.state = eq_st;
                end else if (tk == nkvp_pkg::K_INT) begin
                    act  = A_SCALAR;
                    kind = nkvp_pkg::SK_INT;
                end else if (tk == nkvp_pkg::K_DBL) begin
                    act  = A_SCALAR;
                    kind = nkvp_pkg::SK_DBL;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_REL;
                end
            end
            nkvp_pkg::S_OPEN: begin
                if (tk == nkvp_pkg::K_STR) begin
                    if (nk == nkvp_pkg::K_EQ) begin
                        set_v       = 1'b1;
                        set_ck      = nkvp_pkg::CK_CMP;
                        o_ctl.state = nkvp_pkg::S_NAME;
                        act         = A_PUSH;
                        ev          = nkvp_pkg::EV_ENTRY;
                    end else if (nk == nkvp_pkg::K_STR || nk == nkvp_pkg::K_CB) begin
                        set_v       = 1'b1;
                        set_ck      = nkvp_pkg::CK_STRL;
                        o_ctl.state = nkvp_pkg::S_STRL;
                        act         = A_MEMBER;
                        kind        = nkvp_pkg::SK_STR;
                    end else begin
                        act  = A_FAIL;
                        code = nkvp_pkg::ERR_OPENCOMB;
                    end
                end else if (tk == nkvp_pkg::K_INT) begin
                    if (nk == nkvp_pkg::K_INT || nk == nkvp_pkg::K_CB) begin
                        set_v       = 1'b1;
                        set_ck      = nkvp_pkg::CK_INTL;
                        o_ctl.state = nkvp_pkg::S_INTL;
                        act         = A_MEMBER;
                        kind        = nkvp_pkg::SK_INT;
                    end else if (nk == nkvp_pkg::K_EQ) begin
                        set_v       = 1'b1;
                        set_ck      = nkvp_pkg::CK_CMP;
                        o_ctl.state = nkvp_pkg::S_NAME;
                        act         = A_PUSH;
                        ev          = nkvp_pkg::EV_ENTRY;
                        num         = 1'b1;
                    end else begin
                        act  = A_FAIL;
                        code = nkvp_pkg::ERR_OPENCOMB;
                    end
                end else if (tk == nkvp_pkg::K_DBL) begin
                    set_v       = 1'b1;
                    set_ck      = nkvp_pkg::CK_DBLL;
                    o_ctl.state = nkvp_pkg::S_DBLL;
                    act         = A_MEMBER;
                    kind        = nkvp_pkg::SK_DBL;
                end else if (tk == nkvp_pkg::K_BOOL) begin
                    set_v       = 1'b1;
                    set_ck      = nkvp_pkg::CK_BOOLL;
                    o_ctl.state = nkvp_pkg::S_BOOLL;
                    act         = A_MEMBER;
                    kind        = nkvp_pkg::SK_BOOL;
                end else if (tk == nkvp_pkg::K_OB) begin
                    set_v       = 1'b1;
                    set_ck      = nkvp_pkg::CK_CMPL;
                    o_ctl.state = nkvp_pkg::S_ROOT;
                    act         = A_PUSH;
                    ev          = nkvp_pkg::EV_CMEM;
                    pay         = 64'sd0;
                end else if (tk == nkvp_pkg::K_CB) begin
                    set_v  = 1'b1;
                    set_ck = nkvp_pkg::CK_EMPTY;
                    act    = A_CLOSE;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_OPEN;
                end
            end
            nkvp_pkg::S_INTL: begin
                if (tk == nkvp_pkg::K_CB) begin
                    act = A_CLOSE;
                end else if (tk == nkvp_pkg::K_INT) begin
                    act  = A_MEMBER;
                    kind = nkvp_pkg::SK_INT;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_INTL;
                end
            end
            nkvp_pkg::S_DBLL: begin
                if (tk == nkvp_pkg::K_CB) begin
                    act = A_CLOSE;
                end else if (tk == nkvp_pkg::K_DBL) begin
                    act  = A_MEMBER;
                    kind = nkvp_pkg::SK_DBL;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_DBLL;
                end
            end
            nkvp_pkg::S_CMPL: begin
                if (tk == nkvp_pkg::K_OB) begin
                    o_ctl.state = nkvp_pkg::S_ROOT;
                    act         = A_PUSH;
                    ev          = nkvp_pkg::EV_CMEM;
                    pay         = 64'sd0;
                end else if (tk == nkvp_pkg::K_CB) begin
                    act = A_CLOSE;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_CMPL;
                end
            end
            nkvp_pkg::S_STRL: begin
                if (tk == nkvp_pkg::K_STR) begin
                    act  = A_MEMBER;
                    kind = nkvp_pkg::SK_STR;
                end else if (tk == nkvp_pkg::K_CB) begin
                    act = A_CLOSE;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_STRL;
                end
            end
            nkvp_pkg::S_BOOLL: begin
                if (tk == nkvp_pkg::K_BOOL) begin
                    act  = A_MEMBER;
                    kind = nkvp_pkg::SK_BOOL;
                end else if (tk == nkvp_pkg::K_CB) begin
                    act = A_CLOSE;
                end else begin
                    act  = A_FAIL;
                    code = nkvp_pkg::ERR_BOOLL;
                end
            end
            default: begin
                act  = A_FAIL;
                code = nkvp_pkg::ERR_CMP;
            end
        endcase

        unique case (act)
            A_PUSH: begin
                if (i_depth >= DW'(MAX_DEPTH)) begin
                    o_ctl.fail = 1'b1;
                    o_ctl.err  = nkvp_pkg::ERR_DEEP;
                    main = mk(nkvp_pkg::EV_ERROR, 3'd0, 3'd0, 1'b0, 64'sd0,
                              nkvp_pkg::ERR_DEEP, i_depth);
                end else begin
                    o_ctl.push_we = 1'b1;
                    o_ctl.dop     = nkvp_pkg::D_INC;
                    main = mk(ev, 3'd0, 3'd0, num, pay, 4'd0, i_depth + DW'(1));
                end
            end
            A_SCALAR, A_CLOSE, A_RCLOSE: begin
                if (i_depth <= DW'(1)) begin
                    o_ctl.dop  = nkvp_pkg::D_ZERO;
                    o_ctl.fail = 1'b1;
                    o_ctl.err  = nkvp_pkg::ERR_CLOSE;
                    main = mk(nkvp_pkg::EV_ERROR, 3'd0, 3'd0, 1'b0, 64'sd0,
                              nkvp_pkg::ERR_CLOSE, '0);
                end else begin
                    o_ctl.dop = nkvp_pkg::D_DEC;
                    if (act == A_SCALAR) begin
                        o_ctl.state = nkvp_pkg::S_ROOT;
                        main = mk(nkvp_pkg::EV_SCALAR, kind, rel, 1'b0, pay, 4'd0,
                                  i_depth - DW'(1));
                    end else begin
                        if (act == A_CLOSE) begin
                            o_ctl.state = nkvp_pkg::S_ROOT;
                        end else if (i_mark) begin
                            o_ctl.state = nkvp_pkg::S_CMPL;
                        end
                        main = mk(nkvp_pkg::EV_CLOSE, 3'd0, 3'd0, 1'b0, 64'sd0, 4'd0,
                                  i_depth - DW'(1));
                    end
                end
            end
            A_MEMBER: begin
                main = mk(nkvp_pkg::EV_MEMBER, kind, 3'd0, 1'b0, pay, 4'd0, i_depth);
            end
            A_FAIL: begin
                o_ctl.fail = 1'b1;
                o_ctl.err  = code;
                main = mk(nkvp_pkg::EV_ERROR, 3'd0, 3'd0, 1'b0, 64'sd0, code, i_depth);
            end
            default: ;
        endcase

        has_main     = (act != A_NONE);
        o_ctl.mk_we  = set_v;
        o_ctl.mk_val = (set_ck == nkvp_pkg::CK_CMPL);
        o_ctl.cnt    = {1'b0, set_v} + {1'b0, has_main};
        o_res0       = set_v ? mk(nkvp_pkg::EV_CONT, set_ck, 3'd0, 1'b0, 64'sd0, 4'd0, i_depth)
                             : main;
        o_res0.last  = !(set_v && has_main);
        o_res1       = main;
        o_res1.last  = 1'b1;

        if (i_tok.command) begin
            o_ctl         = '0;
            o_ctl.state   = nkvp_pkg::S_ROOT;
            o_ctl.dop     = nkvp_pkg::D_KEEP;
            o_ctl.restart = 1'b1;
            o_ctl.cnt     = 2'd1;
            if (i_failed) begin
                o_res0 = mk(nkvp_pkg::EV_ERROR, 3'd0, 3'd0, 1'b0, 64'sd0, i_err, i_depth);
            end else if (i_depth != DW'(1) || i_state != nkvp_pkg::S_ROOT) begin
                o_res0 = mk(nkvp_pkg::EV_ERROR, 3'd0, 3'd0, 1'b0, 64'sd0,
                            nkvp_pkg::ERR_END, i_depth);
            end else begin
                o_res0 = mk(nkvp_pkg::EV_END, 3'd0, 3'd0, 1'b0, 64'sd0, 4'd0, i_depth);
            end
            o_res0.last = 1'b1;
        end else if (i_failed) begin
            o_ctl       = '0;
            o_ctl.state = i_state;
            o_ctl.dop   = nkvp_pkg::D_KEEP;
        end
    end

endmodule

// ===== rtl/core/nested_key_value_token_parser.sv =====
`timescale 1ns / 1ps
// Flow: an accepted transaction is registered, processed once the list-mark read is ready and
// the result queue has room for two results, and its results are registered into the queue.
// After each processed transaction the list-mark memory is read again before the next one
// is processed; a new input may be accepted meanwhile. Up to two results per input.
// Reset: synchronous, active low; clears parse state, depth to one and the result queue.
// The list-mark memory is not cleared: each level's mark is written before use.
`include "assert_macros.svh"

module nested_key_value_token_parser #(
    parameter int MAX_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nkvp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output nkvp_pkg::t_out o_out_data
);

    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int AW  = $clog2(MAX_DEPTH);
    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    nkvp_pkg::t_in     r_tok;
    logic              r_tok_vld;
    logic              r_rd_ok;
    nkvp_pkg::t_pstate r_state;
    logic [DW-1:0]     r_depth;
    logic              r_failed;
    logic [3:0]        r_err;

    logic              r_mem [MAX_DEPTH];
    logic              r_rd;
    logic              r_rd_zero;
    logic              r_pw_vld;
    logic [AW-1:0]     r_pw_addr;

    nkvp_pkg::t_out    r_q [QD];
    logic [QAW-1:0]    r_wp;
    logic [QAW-1:0]    r_rp;
    logic [QCW-1:0]    r_cnt;
    logic [QCW-1:0]    n_cnt;

    nkvp_pkg::t_ctl    ctl;
    nkvp_pkg::t_out    res0;
    nkvp_pkg::t_out    res1;

    logic              fire;
    logic              pop;
    logic [DW-1:0]     dm2;
    logic [DW-1:0]     dm1;
    logic              rd_zero;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic              mem_wd;
    logic [1:0]        push_n;
    logic [DW-1:0]     n_depth;

    nkvp_step #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_step (
        .i_tok    (r_tok),
        .i_state  (r_state),
        .i_failed (r_failed),
        .i_err    (r_err),
        .i_depth  (r_depth),
        .i_mark   (r_rd & !r_rd_zero),
        .o_ctl    (ctl),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    assign fire        = r_tok_vld && r_rd_ok && (r_cnt <= QCW'(QD - 2));
    assign o_in_ready  = !r_tok_vld || fire;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_q[r_rp];
    assign pop         = o_out_valid && i_out_ready;
    assign push_n      = fire ? ctl.cnt : 2'd0;
    assign n_cnt       = r_cnt + QCW'(push_n) - QCW'(pop);

    assign dm2     = r_depth - DW'(2);
    assign dm1     = r_depth - DW'(1);
    assign rd_zero = (r_depth <= DW'(2));
    assign rd_addr = rd_zero ? '0 : dm2[AW-1:0];

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pw_addr;
        mem_wd = 1'b0;
        if (fire && ctl.mk_we) begin
            mem_we = 1'b1;
            mem_wa = dm1[AW-1:0];
            mem_wd = ctl.mk_val;
        end else if (r_pw_vld) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        unique case (ctl.dop)
            nkvp_pkg::D_INC:  n_depth = r_depth + DW'(1);
            nkvp_pkg::D_DEC:  n_depth = r_depth - DW'(1);
            nkvp_pkg::D_ZERO: n_depth = '0;
            default:          n_depth = r_depth;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd      <= r_mem[rd_addr];
        r_rd_zero <= rd_zero;
        r_pw_addr <= r_depth[AW-1:0];
        if (o_in_ready && i_in_valid) begin
            r_tok <= i_in_data;
        end
        if (push_n != 2'd0) begin
            r_q[r_wp] <= res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wp + QAW'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_state   <= nkvp_pkg::S_ROOT;
            r_depth   <= DW'(1);
            r_failed  <= 1'b0;
            r_err     <= '0;
            r_pw_vld  <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
        end else begin
            r_rd_ok  <= !fire;
            r_pw_vld <= fire && ctl.push_we;
            if (o_in_ready && i_in_valid) begin
                r_tok_vld <= 1'b1;
            end else if (fire) begin
                r_tok_vld <= 1'b0;
            end
            if (fire) begin
                if (ctl.restart) begin
                    r_state  <= nkvp_pkg::S_ROOT;
                    r_depth  <= DW'(1);
                    r_failed <= 1'b0;
                    r_err    <= '0;
                end else begin
                    r_state <= ctl.state;
                    r_depth <= n_depth;
                    if (ctl.fail) begin
                        r_failed <= 1'b1;
                        r_err    <= ctl.err;
                    end
                end
            end
            r_wp  <= r_wp + QAW'(push_n);
            r_rp  <= r_rp + QAW'(pop);
            r_cnt <= n_cnt;
        end
    end

    `NKVP_NEVER(a_queue_bound, i_clk, i_rst_n, r_cnt > QCW'(QD), "result queue overrun")
    `NKVP_ASSERT(a_interlock, i_clk, i_rst_n, fire |=> !fire, "token processed on stale mark")
    `NKVP_NEVER(a_depth_bound, i_clk, i_rst_n, r_depth > DW'(MAX_DEPTH), "nesting depth out of range")
    `NKVP_ASSERT(a_push_mark, i_clk, i_rst_n, (fire && ctl.push_we) |=> r_pw_vld && !fire, "push mark write lost")

endmodule
